[hw/rtl/tepc_pkg.sv]
// shared types and constants for the timed event pair coalescer
package tepc_pkg;

  localparam int SLOTS = 128;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int WIN_W = 40;
  localparam int PADDR_W = 3;
  localparam logic [WIN_W-1:0] WIN_RESET = 40'd3000000000;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW = 3'd0;

  typedef enum logic [1:0] {
    MODE_PRIMARY = 2'd0,
    MODE_AUDIT   = 2'd1,
    MODE_POLL    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_HELD  = 2'd1,
    VERDICT_READY = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    COMP_UNCHANGED    = 3'd0,
    COMP_NOT_EVAL     = 3'd1,
    COMP_BACKPRESSURE = 3'd2,
    COMP_CORR_MISSING = 3'd3,
    COMP_COALESCED    = 3'd4
  } comp_t;

  typedef struct packed {
    logic used;
    logic hk;
    logic hs;
    logic amb;
    logic em;
  } flag_t;

  typedef struct packed {
    logic [31:0] pid;
    logic [63:0] path;
    logic [62:0] etime;
    logic [63:0] skey;
    logic [15:0] tag;
  } kern_rec_t;

  typedef struct packed {
    logic [31:0] pid;
    logic [63:0] path;
    logic [62:0] etime;
    logic [15:0] tag;
  } sec_rec_t;

  typedef struct packed {
    logic corr;
    logic ge_in;
    logic ge_slot;
  } match_t;

  typedef struct packed {
    verdict_t    verdict;
    comp_t       comp;
    logic [15:0] ktag;
    logic [15:0] stag;
    logic        sv;
  } res_t;

endpackage

[hw/rtl/tepc_if.sv]
// request and response channel interfaces
interface tepc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        is_create;
  logic        eligible;
  logic [31:0] pid;
  logic        path_present;
  logic [63:0] path_key;
  logic [62:0] event_time;
  logic [63:0] start_key;
  logic [63:0] now;
  logic [15:0] record_tag;
  modport source (output valid, mode, is_create, eligible, pid, path_present, path_key,
                  event_time, start_key, now, record_tag, input ready);
  modport sink (input valid, mode, is_create, eligible, pid, path_present, path_key,
                event_time, start_key, now, record_tag, output ready);
endinterface

interface tepc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [2:0]  completeness;
  logic [15:0] kernel_tag;
  logic [15:0] security_tag;
  logic        security_valid;
  modport source (output valid, verdict, completeness, kernel_tag, security_tag,
                  security_valid, input ready);
  modport sink (input valid, verdict, completeness, kernel_tag, security_tag,
                security_valid, output ready);
endinterface

[hw/rtl/tepc_cfg_regs.sv]
// apb window register
module tepc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tepc_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [tepc_pkg::WIN_W-1:0]  window
);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= tepc_pkg::WIN_RESET;
    end else if (psel && penable && pwrite && paddr == tepc_pkg::ADDR_WINDOW) begin
      window <= pwdata[tepc_pkg::WIN_W-1:0];
    end
  end

  assign prdata = (paddr == tepc_pkg::ADDR_WINDOW) ? 64'(window) : 64'd0;
  assign pready = 1'b1;

endmodule

[hw/rtl/tepc_slot_store.sv]
// slot flag and record memories with registered read
module tepc_slot_store (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [tepc_pkg::IDX_W-1:0]     rd_addr,
  input  logic [tepc_pkg::IDX_W-1:0]     wr_addr,
  input  logic                           fwe,
  input  tepc_pkg::flag_t                fdat,
  input  logic                           kwe,
  input  tepc_pkg::kern_rec_t            kdat,
  input  logic                           swe,
  input  tepc_pkg::sec_rec_t             sdat,
  input  logic                           dwe,
  input  logic [63:0]                    ddat,
  output tepc_pkg::flag_t                fq,
  output tepc_pkg::kern_rec_t            kq,
  output tepc_pkg::sec_rec_t             sq,
  output logic [63:0]                    dq
);

  tepc_pkg::flag_t     fmem [tepc_pkg::SLOTS];
  tepc_pkg::kern_rec_t kmem [tepc_pkg::SLOTS];
  tepc_pkg::sec_rec_t  smem [tepc_pkg::SLOTS];
  logic [63:0]         dmem [tepc_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (fwe) fmem[wr_addr] <= fdat;
    if (kwe) kmem[wr_addr] <= kdat;
    if (swe) smem[wr_addr] <= sdat;
    if (dwe) dmem[wr_addr] <= ddat;
    if (rd_en) begin
      fq <= fmem[rd_addr];
      kq <= kmem[rd_addr];
      sq <= smem[rd_addr];
      dq <= dmem[rd_addr];
    end
  end

endmodule

[hw/rtl/tepc_match_unit.sv]
// shared correlation compare for one slot record
module tepc_match_unit (
  input  logic [31:0]                   in_pid,
  input  logic [63:0]                   in_path,
  input  logic [62:0]                   in_time,
  input  logic [31:0]                   slot_pid,
  input  logic [63:0]                   slot_path,
  input  logic [62:0]                   slot_time,
  input  logic [tepc_pkg::WIN_W-1:0]    window,
  output tepc_pkg::match_t              res
);

  logic [62:0] d_is;
  logic [62:0] d_si;
  logic [62:0] absd;

  always_comb begin
    d_is = in_time - slot_time;
    d_si = slot_time - in_time;
    res.ge_in = (in_time >= slot_time);
    res.ge_slot = (slot_time >= in_time);
    absd = res.ge_in ? d_is : d_si;
    res.corr = (slot_pid != 32'd0) && (slot_pid == in_pid) && (slot_path == in_path) &&
               (slot_time != 63'd0) && (in_time != 63'd0) && (absd <= 63'(window));
  end

endmodule

[hw/rtl/timed_event_pair_coalescer.sv]
// timed event pair coalescer top: sequencer, slot flags and result register
// a primary or audit record scans all slots one per cycle, a rate set by the single read
// port of the store; its verdict then passes through the ST_FIN and ST_RESP states
// an audit record matching several slots takes a second scan
// polls stop at the first expired, unemitted kernel slot; immediate verdicts skip the scan
// one item at a time; reset and clear wipe the flags of all slots; window resets to 3000000000
module timed_event_pair_coalescer (
  input  logic                         clk,
  input  logic                         rst,
  tepc_req_if.sink                     req,
  tepc_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tepc_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_FIN, ST_PASS2, ST_RESP, ST_WIPE} state_t;

  localparam logic [tepc_pkg::IDX_W-1:0] LAST = tepc_pkg::IDX_W'(tepc_pkg::SLOTS - 1);
  localparam tepc_pkg::res_t RES_PASS = '{verdict: tepc_pkg::VERDICT_PASS,
                                          comp: tepc_pkg::COMP_UNCHANGED,
                                          ktag: 16'd0, stag: 16'd0, sv: 1'b0};

  state_t state;
  logic [tepc_pkg::CNT_W-1:0] cnt;
  logic ev_valid;
  logic [tepc_pkg::IDX_W-1:0] ev_idx;

  logic [1:0]  mode_r;
  logic [31:0] pid_r;
  logic [63:0] path_r;
  logic [62:0] time_r;
  logic [63:0] sk_r;
  logic [63:0] now_r;
  logic [15:0] tag_r;

  logic same_f, dup_f, conf_f, dirc_f, have_same_f, ff_found;
  logic [1:0] nmatch;
  logic [tepc_pkg::IDX_W-1:0] match_idx, ff_idx;

  tepc_pkg::res_t res, out_res;
  logic out_valid;

  logic [tepc_pkg::WIN_W-1:0] window;
  tepc_pkg::kern_rec_t kq, kdat;
  tepc_pkg::sec_rec_t  sq, sdat;
  logic [63:0] dq, dl_new;
  logic [64:0] dl_sum;
  tepc_pkg::match_t mu;
  logic [31:0] s_pid;
  logic [63:0] s_path;
  logic [62:0] s_time;

  logic acc, issue, last, scan_stop, resp_load;
  tepc_pkg::flag_t cur, fq, match_flag, fl_val;
  logic fl_we, kwe, swe, dwe;
  logic [tepc_pkg::IDX_W-1:0] fl_idx;
  logic expired, live, kc, sc, ks_eq, tomb_free, post_free;
  logic p_match, p_conf, p_same, p_dup, a_match, a_dirc, amb_set;
  logic poll_emit, poll_wipe, p2_amb, conf_all, use_match, is_poll, is_prim;
  tepc_pkg::res_t fin_res, emit_res;
  state_t fin_next;

  tepc_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .window(window)
  );

  tepc_slot_store u_store (
    .clk(clk), .rd_en(issue), .rd_addr(cnt[tepc_pkg::IDX_W-1:0]), .wr_addr(fl_idx),
    .fwe(fl_we), .fdat(fl_val),
    .kwe(kwe), .kdat(kdat), .swe(swe), .sdat(sdat), .dwe(dwe), .ddat(dl_new),
    .fq(fq), .kq(kq), .sq(sq), .dq(dq)
  );

  tepc_match_unit u_match (
    .in_pid(pid_r), .in_path(path_r), .in_time(time_r), .slot_pid(s_pid),
    .slot_path(s_path), .slot_time(s_time), .window(window), .res(mu)
  );

  assign req.ready = (state == ST_IDLE);
  assign acc = req.valid && req.ready;
  assign issue = (state == ST_SCAN || state == ST_PASS2) &&
                 cnt < tepc_pkg::CNT_W'(tepc_pkg::SLOTS);
  assign last = ev_valid && ev_idx == LAST;
  assign is_poll = (mode_r == tepc_pkg::MODE_POLL);
  assign is_prim = (mode_r == tepc_pkg::MODE_PRIMARY);
  assign scan_stop = ev_valid && ((state == ST_SCAN && ((is_poll && poll_emit) || last)) ||
                                  (state == ST_PASS2 && last));
  assign resp_load = (state == ST_RESP) && (!out_valid || rsp.ready);

  assign dl_sum = {1'b0, now_r} + 65'(window);
  assign dl_new = dl_sum[64] ? '1 : dl_sum[63:0];

  assign kdat = '{pid: pid_r, path: path_r, etime: time_r, skey: sk_r, tag: tag_r};
  assign sdat = '{pid: pid_r, path: path_r, etime: time_r, tag: tag_r};

  // per slot evaluation
  always_comb begin
    cur = fq;
    s_pid = cur.hk ? kq.pid : sq.pid;
    s_path = cur.hk ? kq.path : sq.path;
    s_time = cur.hk ? kq.etime : sq.etime;
    expired = (now_r >= dq);
    live = cur.used && !expired;
    kc = live && cur.hk && mu.corr;
    sc = live && !cur.hk && cur.hs && mu.corr;
    ks_eq = (kq.skey == sk_r);
    tomb_free = cur.used && cur.em && expired;
    post_free = !cur.used || tomb_free;
    p_match = sc && mu.ge_slot;
    p_conf = (kc && !ks_eq) || (sc && !mu.ge_slot);
    p_same = kc && ks_eq && !cur.em;
    p_dup = kc && ks_eq && cur.em;
    a_match = kc && mu.ge_in;
    a_dirc = kc && !mu.ge_in && !cur.em;
    amb_set = is_prim ? (kc && !ks_eq && !cur.em) : a_dirc;
    poll_emit = cur.used && !cur.em && expired && cur.hk;
    poll_wipe = cur.used && expired && (cur.em || !cur.hk);
    p2_amb = cur.used && !cur.em && cur.hk && mu.corr;
    emit_res.verdict = tepc_pkg::VERDICT_READY;
    emit_res.ktag = kq.tag;
    emit_res.sv = cur.hs && !cur.amb;
    emit_res.stag = emit_res.sv ? sq.tag : 16'd0;
    if (cur.hs && !cur.amb) emit_res.comp = tepc_pkg::COMP_COALESCED;
    else if (!cur.hs && !cur.amb) emit_res.comp = tepc_pkg::COMP_CORR_MISSING;
    else emit_res.comp = tepc_pkg::COMP_NOT_EVAL;
  end

  // store writes and end of scan decisions
  always_comb begin
    fl_we = 1'b0;
    fl_idx = ev_idx;
    fl_val = cur;
    kwe = 1'b0;
    swe = 1'b0;
    dwe = 1'b0;
    conf_all = conf_f || nmatch == 2'd2;
    use_match = nmatch == 2'd1 && !conf_all;
    fin_res = RES_PASS;
    fin_next = ST_RESP;
    case (state)
      ST_SCAN: begin
        if (ev_valid) begin
          if (is_poll) begin
            if (poll_wipe) begin
              fl_we = 1'b1;
              fl_val = '0;
            end else if (poll_emit) begin
              fl_we = 1'b1;
              fl_val = '{used: 1'b1, hk: 1'b1, hs: 1'b0, amb: 1'b0, em: 1'b1};
              dwe = 1'b1;
            end
          end else if (tomb_free) begin
            fl_we = 1'b1;
            fl_val = '0;
          end else if (amb_set) begin
            fl_we = 1'b1;
            fl_val.amb = 1'b1;
          end
        end
      end
      ST_PASS2: begin
        if (ev_valid && p2_amb) begin
          fl_we = 1'b1;
          fl_val.amb = 1'b1;
        end
      end
      ST_WIPE: begin
        fl_we = 1'b1;
        fl_idx = cnt[tepc_pkg::IDX_W-1:0];
        fl_val = '0;
      end
      ST_FIN: begin
        if (is_prim) begin
          if (same_f) begin
            fin_res.verdict = tepc_pkg::VERDICT_HELD;
          end else if (dup_f) begin
            fin_res.verdict = tepc_pkg::VERDICT_PASS;
          end else if (!use_match && !ff_found) begin
            fin_res.verdict = tepc_pkg::VERDICT_READY;
            fin_res.comp = tepc_pkg::COMP_BACKPRESSURE;
            fin_res.ktag = tag_r;
          end else begin
            fin_res.verdict = tepc_pkg::VERDICT_HELD;
            fl_idx = use_match ? match_idx : ff_idx;
            fl_we = 1'b1;
            kwe = 1'b1;
            if (use_match) begin
              fl_val = match_flag;
              fl_val.hk = 1'b1;
            end else begin
              fl_val = '{used: 1'b1, hk: 1'b1, hs: 1'b0, amb: conf_all, em: 1'b0};
              dwe = 1'b1;
            end
          end
        end else begin
          if (dirc_f) begin
            fin_res.verdict = tepc_pkg::VERDICT_PASS;
          end else if (nmatch == 2'd1 && match_flag.em) begin
            fin_res.verdict = tepc_pkg::VERDICT_PASS;
          end else if (nmatch == 2'd1 && !match_flag.amb) begin
            fin_res.verdict = tepc_pkg::VERDICT_HELD;
            fl_idx = match_idx;
            fl_we = 1'b1;
            fl_val = match_flag;
            fl_val.hs = 1'b1;
            swe = 1'b1;
          end else if (nmatch == 2'd2) begin
            fin_next = ST_PASS2;
          end else if (have_same_f) begin
            fin_res.verdict = tepc_pkg::VERDICT_HELD;
          end else if (ff_found) begin
            fin_res.verdict = tepc_pkg::VERDICT_HELD;
            fl_idx = ff_idx;
            fl_we = 1'b1;
            fl_val = '{used: 1'b1, hk: 1'b0, hs: 1'b1, amb: 1'b0, em: 1'b0};
            swe = 1'b1;
            dwe = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
      cnt <= '0;
      ev_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= resp_load || (out_valid && !rsp.ready);
      if (issue) cnt <= cnt + 1'b1;
      ev_valid <= issue && !scan_stop;
      ev_idx <= cnt[tepc_pkg::IDX_W-1:0];
      case (state)
        ST_IDLE: begin
          if (acc) begin
            mode_r <= req.mode;
            pid_r <= req.pid;
            path_r <= req.path_key;
            time_r <= req.event_time;
            sk_r <= req.start_key;
            now_r <= req.now;
            tag_r <= req.record_tag;
            cnt <= '0;
            same_f <= 1'b0;
            dup_f <= 1'b0;
            conf_f <= 1'b0;
            dirc_f <= 1'b0;
            have_same_f <= 1'b0;
            ff_found <= 1'b0;
            nmatch <= 2'd0;
            if (req.mode == tepc_pkg::MODE_CLEAR) begin
              state <= ST_WIPE;
            end else if (req.mode == tepc_pkg::MODE_POLL) begin
              state <= ST_SCAN;
            end else if (!req.is_create) begin
              res <= RES_PASS;
              state <= ST_RESP;
            end else if (req.mode == tepc_pkg::MODE_AUDIT) begin
              if (req.pid == 32'd0 || !req.path_present || req.event_time == 63'd0) begin
                res <= RES_PASS;
                state <= ST_RESP;
              end else begin
                state <= ST_SCAN;
              end
            end else if (req.start_key == 64'd0 || req.pid == 32'd0 ||
                         !req.path_present || req.event_time == 63'd0) begin
              res <= '{verdict: tepc_pkg::VERDICT_READY, comp: tepc_pkg::COMP_NOT_EVAL,
                       ktag: req.record_tag, stag: 16'd0, sv: 1'b0};
              state <= ST_RESP;
            end else if (!req.eligible) begin
              res <= RES_PASS;
              state <= ST_RESP;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ev_valid) begin
            if (is_prim) begin
              same_f <= same_f | p_same;
              dup_f <= dup_f | p_dup;
              conf_f <= conf_f | p_conf;
            end else begin
              dirc_f <= dirc_f | a_dirc;
              have_same_f <= have_same_f | sc;
            end
            if ((is_prim ? p_match : a_match) && !is_poll) begin
              match_idx <= ev_idx;
              match_flag <= cur;
              if (nmatch != 2'd2) nmatch <= nmatch + 2'd1;
            end
            if (!ff_found && post_free) begin
              ff_found <= 1'b1;
              ff_idx <= ev_idx;
            end
            if (is_poll && poll_emit) begin
              res <= emit_res;
              state <= ST_RESP;
            end else if (last) begin
              state <= is_poll ? ST_IDLE : ST_FIN;
            end
          end
        end
        ST_FIN: begin
          state <= fin_next;
          res <= fin_res;
          cnt <= '0;
        end
        ST_PASS2: begin
          if (last) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_load) begin
            out_res <= res;
            state <= ST_IDLE;
          end
        end
        ST_WIPE: begin
          if (cnt[tepc_pkg::IDX_W-1:0] == LAST) begin
            state <= ST_IDLE;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.verdict = out_res.verdict;
  assign rsp.completeness = out_res.comp;
  assign rsp.kernel_tag = out_res.ktag;
  assign rsp.security_tag = out_res.stag;
  assign rsp.security_valid = out_res.sv;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= tepc_pkg::CNT_W'(tepc_pkg::SLOTS))
    else $error("scan counter past slot count");

  a_ev_in_scan: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == ST_SCAN || state == ST_PASS2))
    else $error("slot evaluation outside a scan");

  a_sv_coalesced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.security_valid |->
      rsp.completeness == tepc_pkg::COMP_COALESCED && rsp.verdict == tepc_pkg::VERDICT_READY)
    else $error("audit merge without coalesced verdict");

  a_held_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.verdict != tepc_pkg::VERDICT_READY |->
      rsp.completeness == tepc_pkg::COMP_UNCHANGED && rsp.kernel_tag == 16'd0)
    else $error("pass or held beat carries ready fields");

endmodule
